FILE: hw/rtl/ftfc_pkg.sv
// Shared types, constants and hash function for the five-tuple flow cache.
`timescale 1ns / 1ps
package ftfc_pkg;
  localparam int MaxFlowsDefault    = 1024;
  localparam int BucketCountDefault = 256;
  localparam int CmdQDepth          = 2;
  localparam int KeyW   = 104;
  localparam int LenW   = 16;
  localparam int TtlW   = 8;
  localparam int TsW    = 48;
  localparam int PktW   = 32;
  localparam int ByteW  = 48;
  localparam int FlowIdW = 10;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_key_t;

  typedef struct packed {
    flow_key_t     key;
    logic [31:0]   hash;
    logic [LenW-1:0] len;
    logic [TtlW-1:0] ttl;
    logic [TsW-1:0]  ts;
  } cmd_t;

  function automatic logic [31:0] bucket_hash(input flow_key_t k);
    logic [31:0] h;
    h = k.src ^ {k.dst[24:0], k.dst[31:25]};
    h = h ^ {k.sport, k.dport};
    h = h ^ (32'(k.proto) * 32'h9E3779B1);
    h = h ^ {16'd0, h[31:16]};
    return h;
  endfunction
endpackage

FILE: hw/rtl/five_tuple_flow_cache_core.sv
// Top level of the five-tuple flow cache.
// A packet is taken from the queue, its bucket head is read, and the chain is walked entry by entry
// until a key match (hit) or the chain end (miss; walk bounded by the flow count), then written back.
// The back end takes a new packet only after write-back of the last one, so the walk sets the rate;
// a two-word queue hides the input handshake, and a waiting result holds the back end in write-back.
// Reset: synchronous active-low; clears flow count, bucket valid bits, queue and FSM.
`timescale 1ns / 1ps
module five_tuple_flow_cache_core import ftfc_pkg::*; #(
  parameter int MaxFlows    = MaxFlowsDefault,
  parameter int BucketCount = BucketCountDefault,
  parameter int QueueDepth  = CmdQDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dport,
  input  logic [15:0] in_pkt_length,
  input  logic [7:0]  in_ttl,
  input  logic [47:0] in_timestamp,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_hit,
  output logic        out_created,
  output logic        out_table_full,
  output logic [9:0]  out_flow_id,
  output logic [31:0] out_packets,
  output logic [47:0] out_total_bytes,
  output logic [15:0] out_min_len,
  output logic [15:0] out_max_len,
  output logic [7:0]  out_min_ttl,
  output logic [7:0]  out_max_ttl,
  output logic [47:0] out_last_seen
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ftfc_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_src_ip, .in_dst_ip, .in_protocol,
    .in_sport, .in_dport, .in_pkt_length, .in_ttl, .in_timestamp,
    .cmd_valid, .cmd, .cmd_take
  );

  ftfc_back #(.MaxFlows(MaxFlows), .BucketCount(BucketCount)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_empty, .out_pop,
    .out_hit, .out_created, .out_table_full, .out_flow_id, .out_packets,
    .out_total_bytes, .out_min_len, .out_max_len, .out_min_ttl,
    .out_max_ttl, .out_last_seen
  );
endmodule

FILE: hw/rtl/ftfc_front.sv
// Front end: accepts packets, masks ports, hashes the key into a short queue.
`timescale 1ns / 1ps
module ftfc_front import ftfc_pkg::*; #(
  parameter int Depth = CmdQDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dport,
  input  logic [15:0] in_pkt_length,
  input  logic [7:0]  in_ttl,
  input  logic [47:0] in_timestamp,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  cmd_t q_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  cmd_t c;
  logic do_push, do_pop;

  always_comb begin
    c.key.src   = in_src_ip;
    c.key.dst   = in_dst_ip;
    c.key.proto = in_protocol;
    if (in_protocol == ProtoTcp || in_protocol == ProtoUdp) begin
      c.key.sport = in_sport;
      c.key.dport = in_dport;
    end else begin
      c.key.sport = '0;
      c.key.dport = '0;
    end
    c.hash = '0;
    c.len  = in_pkt_length;
    c.ttl  = in_ttl;
    c.ts   = in_timestamp;
    c.hash = bucket_hash(c.key);
  end

  assign in_full   = (cnt_r == (AW+1)'(Depth));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !do_pop |=> cnt_r == (AW+1)'(Depth)) else $error("full queue changed");
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_valid |-> !do_pop) else $error("pop from empty queue");
endmodule

FILE: hw/rtl/ftfc_back.sv
// Back end: walks the bucket chain, allocates or updates a flow slot.
`timescale 1ns / 1ps
module ftfc_back import ftfc_pkg::*; #(
  parameter int MaxFlows    = MaxFlowsDefault,
  parameter int BucketCount = BucketCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_hit,
  output logic        out_created,
  output logic        out_table_full,
  output logic [9:0]  out_flow_id,
  output logic [31:0] out_packets,
  output logic [47:0] out_total_bytes,
  output logic [15:0] out_min_len,
  output logic [15:0] out_max_len,
  output logic [7:0]  out_min_ttl,
  output logic [7:0]  out_max_ttl,
  output logic [47:0] out_last_seen
);
  localparam int SW = $clog2(MaxFlows);
  localparam int PW = SW + 1;
  localparam int BW = (BucketCount > 1) ? $clog2(BucketCount) : 1;
  localparam logic [PW-1:0] Nil = PW'(MaxFlows);
  localparam logic [PW-1:0] Full = PW'(MaxFlows);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_FIRST = 6'b000100,
    S_READ  = 6'b001000,
    S_CMP   = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  typedef struct packed {
    logic [PktW-1:0]  pkts;
    logic [ByteW-1:0] bytes;
    logic [LenW-1:0]  lmin;
    logic [LenW-1:0]  lmax;
    logic [TtlW-1:0]  tmin;
    logic [TtlW-1:0]  tmax;
    logic [TsW-1:0]   seen;
  } stats_t;

  // Memories
  logic [PW-1:0] head_mem [BucketCount];
  logic          head_vld_r [BucketCount];
  logic [PW-1:0] link_mem [MaxFlows];
  flow_key_t     key_mem  [MaxFlows];
  stats_t        stat_mem [MaxFlows];

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [BW-1:0] hlo, bkt;
  logic [PW-1:0] cnt_r, slot_r, steps_r, head_r;
  logic          head_v_r;
  flow_key_t     rkey_r;
  logic [PW-1:0] rlink_r;
  stats_t        rstat_r, base, upd;
  logic          created_r, full_r;
  logic          res_v_r, res_v_nxt;
  logic          res_hit_r, res_created_r, res_full_r;
  stats_t        res_r;
  logic [FlowIdW-1:0] res_id_r;
  logic          match, walk_end, res_free, wr_go;
  logic [ByteW:0] bsum;

  // fold the hash into range; any bucket choice gives the same results
  assign hlo = cmd_r.hash[BW-1:0];
  assign bkt = (32'(hlo) >= 32'(BucketCount)) ? BW'(32'(hlo) - 32'(BucketCount)) : hlo;

  // registered reads
  always_ff @(posedge clk) begin
    head_r   <= head_mem[bkt];
    head_v_r <= head_vld_r[bkt];
    rkey_r   <= key_mem[slot_r[SW-1:0]];
    rlink_r  <= link_mem[slot_r[SW-1:0]];
    rstat_r  <= stat_mem[slot_r[SW-1:0]];
  end

  assign match    = (rkey_r == cmd_r.key);
  assign walk_end = (slot_r >= Nil) || (steps_r >= cnt_r);
  assign res_free = !res_v_r || out_pop;
  assign wr_go    = (state_r == S_WRITE) && res_free;
  assign res_v_nxt = (res_v_r && !out_pop) || wr_go;

  always_comb begin
    if (created_r) begin
      base.pkts = '0; base.bytes = '0; base.lmin = '1; base.lmax = '0;
      base.tmin = '1; base.tmax = '0; base.seen = '0;
    end else begin
      base = rstat_r;
    end
    upd = base;
    upd.pkts = (base.pkts == '1) ? base.pkts : base.pkts + 1'b1;
    bsum = {1'b0, base.bytes} + (ByteW+1)'(cmd_r.len);
    upd.bytes = bsum[ByteW] ? '1 : bsum[ByteW-1:0];
    if (cmd_r.len < base.lmin) upd.lmin = cmd_r.len;
    if (cmd_r.len > base.lmax) upd.lmax = cmd_r.len;
    if (cmd_r.ttl < base.tmin) upd.tmin = cmd_r.ttl;
    if (cmd_r.ttl > base.tmax) upd.tmax = cmd_r.ttl;
    upd.seen = cmd_r.ts;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd_valid) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_FIRST;
      S_FIRST: state_nxt = S_READ;
      S_READ:  state_nxt = walk_end ? S_WRITE : S_CMP;
      S_CMP:   state_nxt = match ? S_WRITE : S_READ;
      S_WRITE: if (res_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (cmd_take) cmd_r <= cmd;
    if (wr_go && !full_r) begin
      stat_mem[slot_r[SW-1:0]] <= upd;
      if (created_r) begin
        key_mem[slot_r[SW-1:0]]  <= cmd_r.key;
        link_mem[slot_r[SW-1:0]] <= head_v_r ? head_r : Nil;
        head_mem[bkt] <= slot_r;
      end
    end
    if (wr_go) begin
      res_r         <= full_r ? '0 : upd;
      res_id_r      <= full_r ? '0 : FlowIdW'(slot_r);
      res_hit_r     <= !created_r && !full_r;
      res_created_r <= created_r;
      res_full_r    <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
      created_r <= 1'b0; full_r <= 1'b0;
      slot_r <= '0; steps_r <= '0;
      for (int i = 0; i < BucketCount; i++) head_vld_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_v_r <= res_v_nxt;
      unique case (state_r)
        S_IDLE: if (cmd_valid) begin
          created_r <= 1'b0; full_r <= 1'b0;
          steps_r <= '0;
        end
        S_HEAD: ;
        S_FIRST: slot_r <= head_v_r ? head_r : Nil;
        S_READ: if (walk_end) begin
          // miss: allocate the next slot, or flag a full table
          if (cnt_r >= Full) full_r <= 1'b1;
          else begin
            created_r <= 1'b1;
            slot_r    <= cnt_r;
          end
        end
        S_CMP: if (!match) begin
          slot_r  <= rlink_r;
          steps_r <= steps_r + 1'b1;
        end
        S_WRITE: if (wr_go && !full_r && created_r) begin
          head_vld_r[bkt] <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_empty       = !res_v_r;
  assign out_hit         = res_hit_r;
  assign out_created     = res_created_r;
  assign out_table_full  = res_full_r;
  assign out_flow_id     = res_id_r;
  assign out_packets     = res_r.pkts;
  assign out_total_bytes = res_r.bytes;
  assign out_min_len     = res_r.lmin;
  assign out_max_len     = res_r.lmax;
  assign out_min_ttl     = res_r.tmin;
  assign out_max_ttl     = res_r.tmax;
  assign out_last_seen   = res_r.seen;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Full) else $error("flow count overflow");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !out_pop |=> res_v_r) else $error("result word dropped");
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> cnt_r == Full) else $error("full flag with free slots");
endmodule
